[rtl/udpmc_pkg.sv]
// udpmc_pkg: constants shared by the multicast test packet builder.
// Frame layout codes, header field values and configuration register indexes.
// No dependencies.
`default_nettype none

package udpmc_pkg;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_PORT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_PORT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN  = 3'd4;

  localparam int FRAME_W = 10;
  localparam int SEQ_W = 32;
  localparam int WORD_BYTES = 8;
  localparam int DATA_W = 64;
  localparam int VB_W = 4;

  // Ethernet + IPv4 + UDP headers end at this byte; payload follows
  localparam int HDR_BYTES = 42;
  localparam int HDR_WORDS = 6;
  localparam int ETH_HDR_BYTES = 14;
  localparam int UDP_OFFSET = 34;

  localparam logic [FRAME_W-1:0] MIN_FRAME = 10'd42;

  // reset values of the configuration registers
  localparam logic [31:0] RST_SRC_ADDR  = 32'd167837953;
  localparam logic [31:0] RST_DST_ADDR  = 32'd4009820417;
  localparam logic [15:0] RST_SRC_PORT  = 16'd50000;
  localparam logic [15:0] RST_DST_PORT  = 16'd26477;
  localparam logic [FRAME_W-1:0] RST_FRAME_LEN = 10'd128;

  // header constants
  localparam logic [7:0]  MAC_MCAST_0   = 8'h01;
  localparam logic [7:0]  MAC_MCAST_1   = 8'h00;
  localparam logic [7:0]  MAC_MCAST_2   = 8'h5e;
  localparam logic [7:0]  MAC_LOCAL_0   = 8'h02;
  localparam logic [15:0] ETHERTYPE_IP  = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TOS        = 8'h00;
  localparam logic [15:0] IP_FLAGS_DF   = 16'h4000;
  localparam logic [7:0]  IP_TTL        = 8'd64;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;

endpackage

`default_nettype wire

[rtl/udp_multicast_test_packet_builder.sv]
// Throughput: one 8-byte word per cycle unless out_stall holds the output; a packet of L
//   bytes is ceil(L/8) words (16 for 128 bytes), set by the word sequencer; the next
//   packet follows with no gap.
// Stages: word sequencer -> checksum sum -> checksum fold -> word assembly/output register.
// Reset (rst_n low, synchronous): pipeline emptied, registers back to 10.1.1.1 ->
//   239.1.1.1, ports 50000 -> 26477, 128-byte frames. Uses udpmc_pkg.
`default_nettype none

module udp_multicast_test_packet_builder #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request channel
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic [udpmc_pkg::SEQ_W-1:0]           in_sequence_number,
  // result channel
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic [udpmc_pkg::DATA_W-1:0]          out_frame_word,
  output      logic [udpmc_pkg::VB_W-1:0]            out_valid_bytes,
  output      logic                                  out_end_of_frame,
  // configuration writes
  input  wire logic                                  cfg_valid,
  output      logic                                  cfg_ready,
  input  wire logic [udpmc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [udpmc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int FW = udpmc_pkg::FRAME_W;
  localparam int WORD_W = $clog2(MAX_FRAME_BYTES / udpmc_pkg::WORD_BYTES);
  localparam logic [FW-1:0] MAX_LEN = FW'(MAX_FRAME_BYTES);

  // ---------------- configuration registers ----------------
  logic [31:0]   src_addr_r, dst_addr_r;
  logic [15:0]   src_port_r, dst_port_r;
  logic [FW-1:0] frame_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r  <= udpmc_pkg::RST_SRC_ADDR;
      dst_addr_r  <= udpmc_pkg::RST_DST_ADDR;
      src_port_r  <= udpmc_pkg::RST_SRC_PORT;
      dst_port_r  <= udpmc_pkg::RST_DST_PORT;
      frame_len_r <= udpmc_pkg::RST_FRAME_LEN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        udpmc_pkg::CFG_SRC_ADDR:  src_addr_r  <= cfg_data;
        udpmc_pkg::CFG_DST_ADDR:  dst_addr_r  <= cfg_data;
        udpmc_pkg::CFG_SRC_PORT:  src_port_r  <= cfg_data[15:0];
        udpmc_pkg::CFG_DST_PORT:  dst_port_r  <= cfg_data[15:0];
        udpmc_pkg::CFG_FRAME_LEN: frame_len_r <= cfg_data[FW-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame length and last word index
  logic [FW-1:0]     len_clamped;
  logic [FW-1:0]     len_m1;
  logic [WORD_W-1:0] last_idx;

  always_comb begin
    if (frame_len_r < udpmc_pkg::MIN_FRAME) begin
      len_clamped = udpmc_pkg::MIN_FRAME;
    end else if (frame_len_r > MAX_LEN) begin
      len_clamped = MAX_LEN;
    end else begin
      len_clamped = frame_len_r;
    end
    len_m1   = len_clamped - FW'(1);
    last_idx = WORD_W'(len_m1 >> 3);
  end

  // whole pipeline moves together unless the output holds a stalled word
  logic advance;
  assign advance = !out_valid || !out_stall;

  // ---------------- stage A: word sequencer ----------------
  logic                         a_busy_r;
  logic [udpmc_pkg::SEQ_W-1:0]  a_seq_r;
  logic [FW-1:0]                a_len_r;
  logic [WORD_W-1:0]            a_w_r;
  logic [WORD_W-1:0]            a_last_idx_r;
  logic                         a_at_last;
  logic                         in_acc;

  assign a_at_last = (a_w_r == a_last_idx_r);
  assign in_stall  = !(advance && (!a_busy_r || a_at_last));
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_busy_r <= 1'b0;
    end else if (advance) begin
      if (!a_busy_r || a_at_last) begin
        a_busy_r <= in_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_seq_r      <= in_sequence_number;
      a_len_r      <= len_clamped;
      a_last_idx_r <= last_idx;
      a_w_r        <= '0;
    end else if (advance && a_busy_r) begin
      a_w_r <= a_w_r + WORD_W'(1);
    end
  end

  // ---------------- stage B: header sum, payload base ----------------
  logic                    b_vld_r, b_vld_nxt;
  logic [15:0]             b_id_r;
  logic [7:0]              b_pbase_r, b_pbase_nxt;
  logic [FW-1:0]           b_len_r;
  logic [WORD_W-1:0]       b_w_r;
  logic [udpmc_pkg::VB_W-1:0] b_vbytes_r, b_vbytes_nxt;
  logic                    b_last_r;
  logic [19:0]             b_sum_r, b_sum_nxt;
  logic [WORD_W+2:0]       a_pos;

  function automatic logic [2:0] len_m1_a();
    logic [FW-1:0] t;
    t = a_len_r - FW'(1);
    return t[2:0];
  endfunction

  assign b_vld_nxt = a_busy_r;
  assign a_pos     = {a_w_r, 3'b000};

  always_comb begin
    b_sum_nxt = 20'({udpmc_pkg::IP_VER_IHL, udpmc_pkg::IP_TOS})
              + 20'(udpmc_pkg::IP_FLAGS_DF)
              + 20'({udpmc_pkg::IP_TTL, udpmc_pkg::IP_PROTO_UDP})
              + 20'(16'(a_len_r) - 16'(udpmc_pkg::ETH_HDR_BYTES))
              + 20'(a_seq_r[15:0])
              + 20'(src_addr_r[31:16]) + 20'(src_addr_r[15:0])
              + 20'(dst_addr_r[31:16]) + 20'(dst_addr_r[15:0]);
    // payload byte i of the packet is seq + i, counted from the end of the headers
    b_pbase_nxt = a_seq_r[7:0] + 8'(a_pos) - 8'(udpmc_pkg::HDR_BYTES);
    if (a_at_last) begin
      b_vbytes_nxt = {1'b0, len_m1_a()} + 4'd1;
    end else begin
      b_vbytes_nxt = 4'(udpmc_pkg::WORD_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (advance) begin
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_id_r     <= a_seq_r[15:0];
      b_pbase_r  <= b_pbase_nxt;
      b_len_r    <= a_len_r;
      b_w_r      <= a_w_r;
      b_vbytes_r <= b_vbytes_nxt;
      b_last_r   <= a_at_last;
      b_sum_r    <= b_sum_nxt;
    end
  end

  // ---------------- stage C: fold to ones' complement checksum ----------------
  logic                       c_vld_r;
  logic [15:0]                c_id_r;
  logic [7:0]                 c_pbase_r;
  logic [FW-1:0]              c_len_r;
  logic [WORD_W-1:0]          c_w_r;
  logic [udpmc_pkg::VB_W-1:0] c_vbytes_r;
  logic                       c_last_r;
  logic [15:0]                c_ck_r, c_ck_nxt;
  logic [16:0]                fold1;
  logic [15:0]                fold2;

  always_comb begin
    fold1    = 17'(b_sum_r[15:0]) + 17'(b_sum_r[19:16]);
    fold2    = fold1[15:0] + 16'(fold1[16]);
    c_ck_nxt = ~fold2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (advance) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_id_r     <= b_id_r;
      c_pbase_r  <= b_pbase_r;
      c_len_r    <= b_len_r;
      c_w_r      <= b_w_r;
      c_vbytes_r <= b_vbytes_r;
      c_last_r   <= b_last_r;
      c_ck_r     <= c_ck_nxt;
    end
  end

  // ---------------- stage D: word assembly into the output register ----------------
  logic [7:0]  hdr [64];
  logic [15:0] ip_len, udp_len;
  logic [udpmc_pkg::DATA_W-1:0] word_nxt;
  logic        hdr_word;

  always_comb begin
    ip_len  = 16'(c_len_r) - 16'(udpmc_pkg::ETH_HDR_BYTES);
    udp_len = 16'(c_len_r) - 16'(udpmc_pkg::UDP_OFFSET);
    for (int i = 0; i < 64; i++) begin
      hdr[i] = 8'h00;
    end
    hdr[0]  = udpmc_pkg::MAC_MCAST_0;
    hdr[1]  = udpmc_pkg::MAC_MCAST_1;
    hdr[2]  = udpmc_pkg::MAC_MCAST_2;
    hdr[3]  = {1'b0, dst_addr_r[22:16]};
    hdr[4]  = dst_addr_r[15:8];
    hdr[5]  = dst_addr_r[7:0];
    hdr[6]  = udpmc_pkg::MAC_LOCAL_0;
    hdr[9]  = src_addr_r[23:16];
    hdr[10] = src_addr_r[15:8];
    hdr[11] = src_addr_r[7:0];
    hdr[12] = udpmc_pkg::ETHERTYPE_IP[15:8];
    hdr[13] = udpmc_pkg::ETHERTYPE_IP[7:0];
    hdr[14] = udpmc_pkg::IP_VER_IHL;
    hdr[15] = udpmc_pkg::IP_TOS;
    hdr[16] = ip_len[15:8];
    hdr[17] = ip_len[7:0];
    hdr[18] = c_id_r[15:8];
    hdr[19] = c_id_r[7:0];
    hdr[20] = udpmc_pkg::IP_FLAGS_DF[15:8];
    hdr[21] = udpmc_pkg::IP_FLAGS_DF[7:0];
    hdr[22] = udpmc_pkg::IP_TTL;
    hdr[23] = udpmc_pkg::IP_PROTO_UDP;
    hdr[24] = c_ck_r[15:8];
    hdr[25] = c_ck_r[7:0];
    hdr[26] = src_addr_r[31:24];
    hdr[27] = src_addr_r[23:16];
    hdr[28] = src_addr_r[15:8];
    hdr[29] = src_addr_r[7:0];
    hdr[30] = dst_addr_r[31:24];
    hdr[31] = dst_addr_r[23:16];
    hdr[32] = dst_addr_r[15:8];
    hdr[33] = dst_addr_r[7:0];
    hdr[34] = src_port_r[15:8];
    hdr[35] = src_port_r[7:0];
    hdr[36] = dst_port_r[15:8];
    hdr[37] = dst_port_r[7:0];
    hdr[38] = udp_len[15:8];
    hdr[39] = udp_len[7:0];
  end

  always_comb begin
    logic [5:0] pos;
    logic [7:0] byte_v;
    hdr_word = (c_w_r < WORD_W'(udpmc_pkg::HDR_WORDS));
    word_nxt = '0;
    for (int b = 0; b < udpmc_pkg::WORD_BYTES; b++) begin
      pos = {c_w_r[2:0], 3'(b)};
      if (hdr_word && (pos < 6'(udpmc_pkg::HDR_BYTES))) begin
        byte_v = hdr[pos];
      end else begin
        byte_v = c_pbase_r + 8'(b);
      end
      // bytes past the end of the frame read as zero
      if (4'(b) >= c_vbytes_r) begin
        byte_v = 8'h00;
      end
      word_nxt[udpmc_pkg::DATA_W-1-8*b -: 8] = byte_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_frame_word   <= word_nxt;
      out_valid_bytes  <= c_vbytes_r;
      out_end_of_frame <= c_last_r;
    end
  end

  // ---------------- assertions ----------------
  a_take_starts_packet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> a_busy_r && (a_w_r == '0))
    else $error("accepted request did not start a packet at word 0");

  a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_busy_r |-> (a_w_r <= a_last_idx_r))
    else $error("word index ran past the last word");

  a_full_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_frame |-> (out_valid_bytes == 4'(udpmc_pkg::WORD_BYTES)))
    else $error("short word before end of frame");

  a_bytes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_bytes != '0) && (out_valid_bytes <= 4'(udpmc_pkg::WORD_BYTES)))
    else $error("valid byte count out of range");

  a_no_take_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
    a_busy_r && !a_at_last |-> in_stall)
    else $error("request taken in the middle of a packet");

endmodule

`default_nettype wire

[sim/udpmc_frame_checker.sv]
`timescale 1ns / 100ps
// udpmc_frame_checker: watches the request, packet word and register-write channels of
// the multicast test packet builder, predicts every packet word and compares it.
// Depends on udpmc_pkg for register indexes and header constants.

module udpmc_frame_checker #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [udpmc_pkg::SEQ_W-1:0]   in_sequence_number,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [udpmc_pkg::DATA_W-1:0]  out_frame_word,
  input  logic [udpmc_pkg::VB_W-1:0]    out_valid_bytes,
  input  logic                          out_end_of_frame,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [udpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [udpmc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            mismatches,
  output int                            beats_due,
  output int                            beats_checked
);
  import udpmc_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic [VB_W-1:0]   nbytes;
    logic              last;
  } frame_beat_t;

  frame_beat_t frame_beats_due[$];
  frame_beat_t due;

  logic [31:0]        src_addr_r;
  logic [31:0]        dst_addr_r;
  logic [15:0]        src_port_r;
  logic [15:0]        dst_port_r;
  logic [FRAME_W-1:0] frame_len_r;

  initial begin
    mismatches = 0;
    beats_due = 0;
    beats_checked = 0;
  end

  // Builds the whole packet for one sequence number and queues its words.
  function automatic void build_frame(input logic [SEQ_W-1:0] seq);
    logic [7:0]  pkt [MAX_FRAME_BYTES];
    int unsigned len;
    int unsigned nwords;
    int unsigned nb;
    int          i;
    int          w;
    int          b;
    logic [31:0] sum;
    frame_beat_t beat;

    len = frame_len_r;
    if (len < HDR_BYTES) len = HDR_BYTES;
    if (len > MAX_FRAME_BYTES) len = MAX_FRAME_BYTES;
    for (i = 0; i < MAX_FRAME_BYTES; i++) pkt[i] = 8'h00;

    pkt[0] = MAC_MCAST_0;
    pkt[1] = MAC_MCAST_1;
    pkt[2] = MAC_MCAST_2;
    pkt[3] = {1'b0, dst_addr_r[22:16]};
    pkt[4] = dst_addr_r[15:8];
    pkt[5] = dst_addr_r[7:0];
    pkt[6] = MAC_LOCAL_0;
    pkt[7] = 8'h00;
    pkt[8] = 8'h00;
    pkt[9] = src_addr_r[23:16];
    pkt[10] = src_addr_r[15:8];
    pkt[11] = src_addr_r[7:0];
    {pkt[12], pkt[13]} = ETHERTYPE_IP;

    pkt[14] = IP_VER_IHL;
    pkt[15] = IP_TOS;
    {pkt[16], pkt[17]} = 16'(len - ETH_HDR_BYTES);
    {pkt[18], pkt[19]} = seq[15:0];
    {pkt[20], pkt[21]} = IP_FLAGS_DF;
    pkt[22] = IP_TTL;
    pkt[23] = IP_PROTO_UDP;
    {pkt[26], pkt[27], pkt[28], pkt[29]} = src_addr_r;
    {pkt[30], pkt[31], pkt[32], pkt[33]} = dst_addr_r;

    // one's complement sum over the 20-byte IP header, checksum field still zero
    sum = '0;
    for (i = ETH_HDR_BYTES; i < UDP_OFFSET; i += 2) sum += {16'h0, pkt[i], pkt[i+1]};
    while (sum[31:16] != 16'h0) sum = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
    {pkt[24], pkt[25]} = ~sum[15:0];

    {pkt[34], pkt[35]} = src_port_r;
    {pkt[36], pkt[37]} = dst_port_r;
    {pkt[38], pkt[39]} = 16'(len - UDP_OFFSET);

    for (i = HDR_BYTES; i < len; i++) pkt[i] = seq[7:0] + 8'(i - HDR_BYTES);

    nwords = (len + WORD_BYTES - 1) / WORD_BYTES;
    for (w = 0; w < nwords; w++) begin
      nb = len - w * WORD_BYTES;
      if (nb > WORD_BYTES) nb = WORD_BYTES;
      beat.word = '0;
      for (b = 0; b < WORD_BYTES; b++)
        beat.word = {beat.word[DATA_W-9:0], (b < nb) ? pkt[w*WORD_BYTES + b] : 8'h00};
      beat.nbytes = VB_W'(nb);
      beat.last = (w + 1 == nwords);
      frame_beats_due = {frame_beats_due, beat};
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r = RST_SRC_ADDR;
      dst_addr_r = RST_DST_ADDR;
      src_port_r = RST_SRC_PORT;
      dst_port_r = RST_DST_PORT;
      frame_len_r = RST_FRAME_LEN;
      frame_beats_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SRC_ADDR:  src_addr_r = cfg_data;
          CFG_DST_ADDR:  dst_addr_r = cfg_data;
          CFG_SRC_PORT:  src_port_r = cfg_data[15:0];
          CFG_DST_PORT:  dst_port_r = cfg_data[15:0];
          CFG_FRAME_LEN: frame_len_r = cfg_data[FRAME_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (frame_beats_due.size() == 0) begin
          mismatches++;
          $display("%0t: word with nothing expected, actual %h bytes %0d last %0b",
                   $time, out_frame_word, out_valid_bytes, out_end_of_frame);
        end else begin
          due = frame_beats_due.pop_front();
          beats_checked++;
          if (out_frame_word !== due.word) begin
            mismatches++;
            $display("%0t: frame_word expected %h actual %h",
                     $time, due.word, out_frame_word);
          end
          if (out_valid_bytes !== due.nbytes) begin
            mismatches++;
            $display("%0t: valid_bytes expected %0d actual %0d",
                     $time, due.nbytes, out_valid_bytes);
          end
          if (out_end_of_frame !== due.last) begin
            mismatches++;
            $display("%0t: end_of_frame expected %0b actual %0b",
                     $time, due.last, out_end_of_frame);
          end
        end
      end

      if (in_valid && !in_stall) build_frame(in_sequence_number);
    end
    beats_due = frame_beats_due.size();
  end

endmodule

[sim/udp_multicast_test_packet_builder_tb.sv]
`timescale 1ns / 100ps
// udp_multicast_test_packet_builder_tb: request and register-write stimulus for the
// multicast test packet builder, with idle/stall phases; checking is in udpmc_frame_checker.
// Depends on udpmc_pkg, udp_multicast_test_packet_builder and udpmc_frame_checker.

module udp_multicast_test_packet_builder_tb;
  import udpmc_pkg::*;

  localparam int MAX_FRAME = 512;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 20;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [SEQ_W-1:0]       in_sequence_number;
  logic                   out_valid;
  logic                   out_stall;
  logic [DATA_W-1:0]      out_frame_word;
  logic [VB_W-1:0]        out_valid_bytes;
  logic                   out_end_of_frame;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int beats_due;
  int beats_checked;
  int send_gap_pct;
  int stall_pct;
  int requests_sent;
  int cfg_writes;
  int idle_cycles;

  udp_multicast_test_packet_builder #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sequence_number(in_sequence_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_frame_word(out_frame_word),
    .out_valid_bytes(out_valid_bytes),
    .out_end_of_frame(out_end_of_frame),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  udpmc_frame_checker #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) u_frame_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_sequence_number(in_sequence_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_frame_word(out_frame_word),
    .out_valid_bytes(out_valid_bytes),
    .out_end_of_frame(out_end_of_frame),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .beats_due(beats_due),
    .beats_checked(beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // ends the run if no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no channel activity for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Called at a falling edge; leaves in_valid high after the request is taken.
  task automatic send_request(input logic [SEQ_W-1:0] seq);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sequence_number <= seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    @(negedge clk);
  endtask

  // Full register set; with with_spare, spare indexes get random data and must have no effect.
  task automatic write_regs(input logic [31:0] src, input logic [31:0] dst,
                            input logic [15:0] sport, input logic [15:0] dport,
                            input logic [31:0] flen, input bit with_spare);
    int k;
    cfg_write(CFG_SRC_ADDR, src);
    cfg_write(CFG_DST_ADDR, dst);
    cfg_write(CFG_SRC_PORT, {16'($urandom_range(0, 65535)), sport});
    cfg_write(CFG_DST_PORT, {16'($urandom_range(0, 65535)), dport});
    if (with_spare)
      for (k = CFG_FRAME_LEN + 1; k < (1 << CFG_IDX_W); k++)
        cfg_write(CFG_IDX_W'(k), $urandom);
    cfg_write(CFG_FRAME_LEN, flen);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every predicted word is out, then lets the pipeline settle.
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (beats_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] directed_len [10];
    logic [31:0] flen;
    logic [31:0] seq;
    int          p;
    int          n;
    int          r;

    directed_len = '{32'd41, 32'd42, 32'd43, 32'd49, 32'd127,
                     32'd511, 32'd512, 32'd513, 32'd1023, 32'hFFFF_FC00};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sequence_number = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_gap_pct = 0;
    stall_pct = 0;
    requests_sent = 0;
    cfg_writes = 0;
    idle_cycles = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values
    send_request(32'h0000_0000);
    send_request(32'hFFFF_FFFF);
    drain();

    // all-zero and all-one register extremes; frame 0 is raised to the minimum
    write_regs(32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 1'b0);
    send_request(32'h0000_00FF);
    send_request(32'h8000_0000);
    drain();
    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd1023, 1'b1);
    send_request(32'h7FFF_FFFF);
    send_request(32'h0000_FFFF);
    drain();

    // length clamping and partial last words
    for (n = 0; n < 10; n++) begin
      write_regs($urandom, $urandom, 16'($urandom), 16'($urandom), directed_len[n], n == 3);
      send_request(n[0] ? 32'hAAAA_AAAA : 32'h5555_5555 + n);
      drain();
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 85; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 85; end
        default: begin send_gap_pct = 34; stall_pct = 34; end
      endcase
      // mostly short frames; some clamped, a few at the maximum
      r = $urandom_range(0, 99);
      if (r < 10)      flen = $urandom_range(0, 41);
      else if (r < 20) flen = $urandom_range(513, 1023);
      else if (r < 28) flen = MAX_FRAME;
      else             flen = $urandom_range(42, 120);
      if ($urandom_range(0, 2) == 0) flen[31:FRAME_W] = 22'($urandom);
      drain();
      write_regs($urandom, $urandom, 16'($urandom), 16'($urandom), flen,
                 $urandom_range(0, 3) == 0);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 70)      seq = $urandom;
        else if (r < 85) seq = {24'hFF_FFFF, 8'($urandom_range(192, 255))};
        else             seq = $urandom_range(0, 300);
        send_request(seq);
      end
    end

    send_gap_pct = 0;
    stall_pct = 0;
    drain();
    $display("covered %0d packet requests and %0d register writes (%0d directed settings,",
             requests_sent, cfg_writes, 13);
    $display("  %0d random phases); %0d packet words compared", RAND_PHASES, beats_checked);
    if (mismatches == 0 && beats_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
